>>> rtl/core/spsres_pkg.sv
// Shared types and constants for the H.264 SPS resolution parser.
// Holds the parse phase encoding, status codes, parser state and pending-result records.
// No dependencies.
package spsres_pkg;

	typedef enum logic [29:0] {
		PH_HDR       = 30'b1 << 0,
		PH_PROFILE   = 30'b1 << 1,
		PH_CONSTR    = 30'b1 << 2,
		PH_SPSID     = 30'b1 << 3,
		PH_CHROMA    = 30'b1 << 4,
		PH_SEPCOL    = 30'b1 << 5,
		PH_BDL       = 30'b1 << 6,
		PH_BDC       = 30'b1 << 7,
		PH_BYPASS    = 30'b1 << 8,
		PH_SCALING   = 30'b1 << 9,
		PH_LOG2FN    = 30'b1 << 10,
		PH_POCTYPE   = 30'b1 << 11,
		PH_POCLSB    = 30'b1 << 12,
		PH_DZERO     = 30'b1 << 13,
		PH_OFFNR     = 30'b1 << 14,
		PH_OFFTB     = 30'b1 << 15,
		PH_NCYCLE    = 30'b1 << 16,
		PH_OFFREF    = 30'b1 << 17,
		PH_MAXREF    = 30'b1 << 18,
		PH_GAPS      = 30'b1 << 19,
		PH_WIDTH     = 30'b1 << 20,
		PH_HEIGHT    = 30'b1 << 21,
		PH_FRAMEONLY = 30'b1 << 22,
		PH_MBAFF     = 30'b1 << 23,
		PH_DIRECT    = 30'b1 << 24,
		PH_CROPFLAG  = 30'b1 << 25,
		PH_CROPL     = 30'b1 << 26,
		PH_CROPR     = 30'b1 << 27,
		PH_CROPT     = 30'b1 << 28,
		PH_CROPB     = 30'b1 << 29
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_TRUNC   = 3'd1,
		ST_GOLOMB  = 3'd2,
		ST_SCALING = 3'd3,
		ST_CODEC   = 3'd4,
		ST_RANGE   = 3'd5
	} status_t;

	// Crop unit class derived from chroma_format_idc.
	typedef enum logic [1:0] {
		CHR_OTHER = 2'd0,
		CHR_420   = 2'd1,
		CHR_422   = 2'd2
	} chroma_t;

	localparam logic [1:0] CODEC_AVC = 2'd0;

	typedef struct packed {
		phase_t      phase;
		logic [5:0]  lz;
		logic [31:0] acc;
		logic [5:0]  bl;
		logic [7:0]  prof;
		chroma_t     chroma;
		logic [31:0] ocr;
		logic [31:0] wmm1;
		logic [31:0] hum1;
		logic        fo;
		logic [32:0] ch;
		logic [32:0] cv;
		logic        rg;
		status_t     status;
		logic        fin;
	} ps_t;

	// A result on its way out: either a final status, or a size still to be checked.
	typedef struct packed {
		status_t     status;
		logic        fin;
		logic [31:0] wmm1;
		logic [31:0] hum1;
		logic        fo;
		chroma_t     chroma;
		logic [32:0] ch;
		logic [32:0] cv;
	} pend_t;

	// Fixed field length of a phase; zero marks an Exp-Golomb field.
	function automatic logic [5:0] flen(phase_t p);
		case (p)
			PH_PROFILE: return 6'd8;
			PH_CONSTR: return 6'd16;
			PH_SEPCOL, PH_BYPASS, PH_SCALING, PH_DZERO, PH_GAPS, PH_FRAMEONLY,
			PH_MBAFF, PH_DIRECT, PH_CROPFLAG: return 6'd1;
			default: return 6'd0;
		endcase
	endfunction

endpackage

>>> rtl/core/spsres_parse.sv
// Bit-level SPS field parser: eight bit steps per byte, holds the parse state.
// Depends on spsres_pkg.
module spsres_parse import spsres_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [1:0]  codec_select,
	output logic        emit,
	output pend_t       pend
);

	ps_t st_q;
	ps_t s_w;
	ps_t st_d;
	logic before_w;

	function automatic ps_t clear_st();
		ps_t s;
		s = '0;
		s.phase = PH_HDR;
		s.chroma = CHR_420;
		return s;
	endfunction

	function automatic ps_t go(ps_t s, phase_t p);
		s.phase = p;
		s.lz = '0;
		s.acc = '0;
		s.bl = flen(p);
		return s;
	endfunction

	function automatic ps_t give(ps_t s, status_t c);
		s.rg = 1'b1;
		s.status = c;
		s.fin = 1'b0;
		return s;
	endfunction

	function automatic ps_t finish(ps_t s);
		s.rg = 1'b1;
		s.status = ST_OK;
		s.fin = 1'b1;
		return s;
	endfunction

	function automatic logic is_high(logic [7:0] p);
		return p inside {8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86,
			8'd118, 8'd128, 8'd138};
	endfunction

	function automatic ps_t field_done(ps_t s, logic [31:0] v);
		case (s.phase)
			PH_PROFILE: begin
				s.prof = v[7:0];
				s = go(s, PH_CONSTR);
			end
			PH_CONSTR: s = go(s, PH_SPSID);
			PH_SPSID: s = go(s, is_high(s.prof) ? PH_CHROMA : PH_LOG2FN);
			PH_CHROMA: begin
				s.chroma = (v == 32'd1) ? CHR_420 : ((v == 32'd2) ? CHR_422 : CHR_OTHER);
				s = go(s, (v == 32'd3) ? PH_SEPCOL : PH_BDL);
			end
			PH_SEPCOL: s = go(s, PH_BDL);
			PH_BDL: s = go(s, PH_BDC);
			PH_BDC: s = go(s, PH_BYPASS);
			PH_BYPASS: s = go(s, PH_SCALING);
			PH_SCALING: begin
				if (v != '0) s = give(s, ST_SCALING);
				else s = go(s, PH_LOG2FN);
			end
			PH_LOG2FN: s = go(s, PH_POCTYPE);
			PH_POCTYPE: s = go(s, (v == '0) ? PH_POCLSB
				: ((v == 32'd1) ? PH_DZERO : PH_MAXREF));
			PH_POCLSB: s = go(s, PH_MAXREF);
			PH_DZERO: s = go(s, PH_OFFNR);
			PH_OFFNR: s = go(s, PH_OFFTB);
			PH_OFFTB: s = go(s, PH_NCYCLE);
			PH_NCYCLE: begin
				s.ocr = v;
				s = go(s, (v != '0) ? PH_OFFREF : PH_MAXREF);
			end
			PH_OFFREF: begin
				s.ocr = s.ocr - 32'd1;
				s = go(s, (s.ocr != '0) ? PH_OFFREF : PH_MAXREF);
			end
			PH_MAXREF: s = go(s, PH_GAPS);
			PH_GAPS: s = go(s, PH_WIDTH);
			PH_WIDTH: begin
				s.wmm1 = v;
				s = go(s, PH_HEIGHT);
			end
			PH_HEIGHT: begin
				s.hum1 = v;
				s = go(s, PH_FRAMEONLY);
			end
			PH_FRAMEONLY: begin
				s.fo = v[0];
				s = go(s, v[0] ? PH_DIRECT : PH_MBAFF);
			end
			PH_MBAFF: s = go(s, PH_DIRECT);
			PH_DIRECT: s = go(s, PH_CROPFLAG);
			PH_CROPFLAG: begin
				if (v != '0) s = go(s, PH_CROPL);
				else s = finish(s);
			end
			PH_CROPL: begin
				s.ch = s.ch + {1'b0, v};
				s = go(s, PH_CROPR);
			end
			PH_CROPR: begin
				s.ch = s.ch + {1'b0, v};
				s = go(s, PH_CROPT);
			end
			PH_CROPT: begin
				s.cv = s.cv + {1'b0, v};
				s = go(s, PH_CROPB);
			end
			PH_CROPB: begin
				s.cv = s.cv + {1'b0, v};
				s = finish(s);
			end
			default: s = give(s, ST_TRUNC);
		endcase
		return s;
	endfunction

	function automatic ps_t take_bit(ps_t s, logic b);
		logic [5:0] len;
		logic [32:0] val;
		len = flen(s.phase);
		val = '0;
		if (len != '0) begin
			s.acc = {s.acc[30:0], b};
			if (s.bl != '0) s.bl = s.bl - 6'd1;
			if (s.bl == '0) s = field_done(s, s.acc);
		end else if (s.bl == '0) begin
			if (b) begin
				if (s.lz == '0) begin
					s = field_done(s, '0);
				end else begin
					s.bl = s.lz;
					s.acc = '0;
				end
			end else begin
				s.lz = s.lz + 6'd1;
				if (s.lz >= 6'd32) s = give(s, ST_GOLOMB);
			end
		end else begin
			s.acc = {s.acc[30:0], b};
			s.bl = s.bl - 6'd1;
			if (s.bl == '0) begin
				val = (33'd1 << s.lz[4:0]) - 33'd1 + {1'b0, s.acc};
				s = field_done(s, val[31:0]);
			end
		end
		return s;
	endfunction

	// One byte: header check or eight bit steps, then the end-of-set handling.
	always_comb begin
		s_w = st_q;
		before_w = st_q.rg;
		if (!s_w.rg) begin
			if (s_w.phase == PH_HDR) begin
				if (codec_select != CODEC_AVC) s_w = give(s_w, ST_CODEC);
				else s_w = go(s_w, PH_PROFILE);
			end else begin
				for (int i = 7; i >= 0; i--) begin
					if (!s_w.rg) s_w = take_bit(s_w, data_byte[3'(i)]);
				end
			end
		end
		if (last_byte && !s_w.rg) s_w = give(s_w, ST_TRUNC);
		st_d = last_byte ? clear_st() : s_w;
	end

	assign emit = s_w.rg && !before_w;
	assign pend = '{status: s_w.status, fin: s_w.fin, wmm1: s_w.wmm1, hum1: s_w.hum1,
		fo: s_w.fo, chroma: s_w.chroma, ch: s_w.ch, cv: s_w.cv};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= clear_st();
		end else if (take) begin
			st_q <= st_d;
		end
	end

endmodule

>>> rtl/core/spsres_size.sv
// Size and crop check: turns a pending result into status, width and height.
// Depends on spsres_pkg.
module spsres_size import spsres_pkg::*; #(
	parameter int MAX_SIDE_MBS = 1024
) (
	input  pend_t        pend,
	output status_t      status,
	output logic [15:0]  image_width,
	output logic [15:0]  image_height
);

	logic [32:0] wmbs;
	logic [32:0] hm;
	logic [33:0] hmbs;
	logic [36:0] wpix;
	logic [37:0] hpix;
	logic [34:0] cw;
	logic [33:0] cvu;
	logic [34:0] chh;
	logic over;

	always_comb begin
		wmbs = {1'b0, pend.wmm1} + 33'd1;
		hm = {1'b0, pend.hum1} + 33'd1;
		hmbs = pend.fo ? {1'b0, hm} : {hm, 1'b0};
		over = (wmbs > 33'(MAX_SIDE_MBS)) || (hmbs > 34'(MAX_SIDE_MBS));
		wpix = {wmbs, 4'b0};
		hpix = {hmbs, 4'b0};
		cw = (pend.chroma != CHR_OTHER) ? {1'b0, pend.ch, 1'b0} : {2'b0, pend.ch};
		cvu = (pend.chroma == CHR_420) ? {pend.cv, 1'b0} : {1'b0, pend.cv};
		chh = pend.fo ? {1'b0, cvu} : {cvu, 1'b0};
		status = pend.status;
		image_width = '0;
		image_height = '0;
		if (pend.fin) begin
			if (over || ({2'b0, cw} >= wpix) || ({3'b0, chh} >= hpix)) begin
				status = ST_RANGE;
			end else begin
				status = ST_OK;
				image_width = 16'(wpix - {2'b0, cw});
				image_height = 16'(hpix - {3'b0, chh});
			end
		end
	end

endmodule

>>> rtl/core/h264_sps_resolution_parser_core.sv
// Top level of the H.264 SPS resolution parser.
// Depends on spsres_pkg, spsres_parse and spsres_size.
//
// Usage: the bytes of one sequence parameter set enter on the data channel, one beat per
// byte, NAL header byte first, with last_byte high on the final byte. At most one result
// beat per parameter set leaves on the result channel, carrying a status and, when the
// status is ok, the cropped picture width and height.
// Both channels use valid and stall: a beat moves on a rising edge where valid is high
// and stall is low.
// A byte sits in the input register, is parsed into the pending register, and the size
// check feeds the result register. Throughput: one byte per cycle while data_stall is
// low; each byte after the NAL header is consumed by eight bit steps of the field parser
// combinationally, and the three registers each hold one beat.
// When the receiver stalls, the result register holds, then the pending and input
// registers fill, and only after all three are full is data_stall raised.
// Reset clears the parse state, the codec selection (AVC) and all valid flags; after
// every last byte the parser returns to expecting a new NAL header. codec_select is
// written through cfg_wr_en by the user only while idle; the block does not enforce it.
module h264_sps_resolution_parser_core import spsres_pkg::*; #(
	parameter int MAX_SIDE_MBS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  codec_select,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic [15:0] image_width,
	output logic [15:0] image_height
);

	logic [1:0] codec_q;
	logic v_s1;
	logic [7:0] byte_s1;
	logic last_s1;
	logic v_s2;
	pend_t pend_s2;
	logic result_valid_q;
	status_t status_q;
	logic [15:0] width_q;
	logic [15:0] height_q;

	logic adv_o;
	logic adv_2;
	logic adv_1;
	logic emit;
	pend_t pend_w;
	status_t size_status;
	logic [15:0] size_width;
	logic [15:0] size_height;

	// Each register moves when it is empty or when the one after it moves.
	assign adv_o = !result_valid_q || !result_stall;
	assign adv_2 = !v_s2 || adv_o;
	assign adv_1 = !v_s1 || adv_2;
	assign data_stall = !adv_1;

	// The parser consumes the byte in the input register when it can move on.
	spsres_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.take(v_s1 && adv_2),
		.data_byte(byte_s1),
		.last_byte(last_s1),
		.codec_select(codec_q),
		.emit(emit),
		.pend(pend_w)
	);

	spsres_size #(.MAX_SIDE_MBS(MAX_SIDE_MBS)) u_size (
		.pend(pend_s2),
		.status(size_status),
		.image_width(size_width),
		.image_height(size_height)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_q <= CODEC_AVC;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) codec_q <= codec_select;
			if (adv_1) v_s1 <= data_valid;
			if (adv_2) v_s2 <= v_s1 && emit;
			if (adv_o) result_valid_q <= v_s2;
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (adv_1) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
		if (adv_2) pend_s2 <= pend_w;
		if (adv_o) begin
			status_q <= size_status;
			width_q <= size_width;
			height_q <= size_height;
		end
	end

	assign result_valid = result_valid_q;
	assign status = status_q;
	assign image_width = width_q;
	assign image_height = height_q;

	// A failing status never carries a picture size.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && (status_q != ST_OK) |-> (width_q == '0) && (height_q == '0))
		else $error("size reported with a failing status");

	// Input back-pressure only when the whole chain is full and the receiver stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> v_s1 && v_s2 && result_valid_q && result_stall)
		else $error("input stalled while the pipeline has room");

	// A pending result is not lost while the result register is held.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && result_valid_q && result_stall |=> v_s2)
		else $error("pending result dropped during stall");

endmodule
